/* src/two_link_planar_inverse_kinematics_assert.svh */
// assertion macros for the two-link arm solver checker
`ifndef TWO_LINK_PLANAR_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_PLANAR_INVERSE_KINEMATICS_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define TLIK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define TLIK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tlik_pkg.sv */
// shared types, widths and constants of the two-link arm solver
`timescale 1ns / 1ps
`default_nettype none
package tlik_pkg;
	// port widths
	localparam int COORD_W    = 16;
	localparam int LINK_W     = 15;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER = 1'b0,
		REG_LOWER = 1'b1
	} cfg_reg_t;
	localparam logic [LINK_W-1:0] UPPER_RST = 15'd5120;
	localparam logic [LINK_W-1:0] LOWER_RST = 15'd4096;

	// front end arithmetic
	localparam int SQ_W   = 31;
	localparam int LSQ_W  = 30;
	localparam int NUM_W  = 33;
	localparam int DEN_W  = 31;
	localparam int RAD_W  = 62;
	localparam int ROOT_W = 31;
	localparam int REM_W  = 33;

	// arctangent units
	localparam int ITER_DEF  = 16;
	localparam int ATAN_LEN  = 24;
	localparam int MAG_W     = 48;
	localparam int SIG_W     = 49;
	localparam int POS_W     = 6;
	localparam int NORM_MSB  = 29;
	localparam int CX_W      = 33;
	localparam int Z_W       = 25;
	localparam int ANG_W     = 25;
	localparam int NUM_LANES = 3;
	localparam int LANE_YX   = 0;
	localparam int LANE_ELB  = 1;
	localparam int LANE_OFF  = 2;
	localparam logic signed [Z_W-1:0] DEG_90  = 25'sd5898240;
	localparam logic signed [Z_W-1:0] DEG_180 = 25'sd11796480;
	// atan(2^-i) in 2^-16 degree
	localparam logic [22:0] ATAN_TAB [ATAN_LEN] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
		23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
		23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
		23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
	};

	// back end
	localparam int T_W      = 27;
	localparam int RND_SH   = 10;
	localparam int A1_W     = 17;
	localparam int A2_W     = 15;
	localparam int SH_ANG_W = 16;
	localparam int EL_ANG_W = 14;
	localparam int N_W      = 19;
	localparam int RECIP_W  = 20;
	localparam int PROD_W   = 39;
	localparam int RECIP_SH = 25;
	localparam int CNT_W    = 14;
	localparam int SERVO_W  = 12;
	localparam logic signed [A1_W-1:0] SHOULDER_MIN = -17'sd23040;
	localparam logic signed [A1_W-1:0] SHOULDER_MAX = 17'sd11520;
	localparam logic signed [A2_W-1:0] ELBOW_MAX    = 15'sd11520;
	localparam logic signed [N_W:0]    SERVO_MID_X8 = 20'sd92160;
	localparam logic [RECIP_W-1:0]     RECIP_45     = 20'd745655;
	localparam logic [CNT_W-1:0]       SERVO_MAX    = 14'd4095;

	// stage control handed to the pipelined units
	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	// per-lane operand signs and zero mark
	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
	} lane_flag_t;

	// words carried alongside the square root
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [LINK_W-1:0]         l1;
		logic [LINK_W-1:0]         l2;
		logic signed [NUM_W-1:0]   num;
		logic [DEN_W-1:0]          den;
		logic                      reach;
	} sq_sb_t;
endpackage
`default_nettype wire

/* src/tlik_sqrt.sv */
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tlik_sqrt #(
	parameter int SB_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlik_pkg::pipe_ctl_t           ctl,
	input  logic [tlik_pkg::RAD_W-1:0]    rad,
	input  logic [SB_W-1:0]               in_sb,
	output logic                          out_vld,
	output logic [tlik_pkg::ROOT_W-1:0]   root,
	output logic [SB_W-1:0]               out_sb
);
	import tlik_pkg::*;
	localparam int NS = ROOT_W;

	logic [NS-1:0]     vld_s;
	logic [SB_W-1:0]   sb_s   [NS];
	logic [RAD_W-1:0]  rad_s  [NS];
	logic [REM_W-1:0]  rem_s  [NS];
	logic [ROOT_W-1:0] root_s [NS];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= {vld_s[NS-2:0], ctl.vld};
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [RAD_W-1:0]  rad_p;
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [SB_W-1:0]   sb_p;
		logic [REM_W-1:0]  rem_t;
		logic [REM_W-1:0]  trial;

		if (k == 0) begin : g_first
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign sb_p   = in_sb;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign sb_p   = sb_s[k-1];
		end

		// bring down two radicand bits and try the next root bit
		assign rem_t = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
		assign trial = {root_p[ROOT_W-2:0], 2'b01};

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rad_s[k] <= {rad_p[RAD_W-3:0], 2'b00};
				sb_s[k]  <= sb_p;
				if (rem_t >= trial) begin
					rem_s[k]  <= rem_t - trial;
					root_s[k] <= {root_p[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_t;
					root_s[k] <= {root_p[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign root    = root_s[NS-1];
	assign out_sb  = sb_s[NS-1];
endmodule
`default_nettype wire

/* src/tlik_cordic.sv */
// three-lane pipelined vectoring cordic giving full-circle angles
`timescale 1ns / 1ps
`default_nettype none
module tlik_cordic #(
	parameter int ITER = tlik_pkg::ITER_DEF,
	parameter int SB_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlik_pkg::pipe_ctl_t               ctl,
	input  logic signed [tlik_pkg::SIG_W-1:0] xv    [tlik_pkg::NUM_LANES],
	input  logic signed [tlik_pkg::SIG_W-1:0] yv    [tlik_pkg::NUM_LANES],
	input  logic [SB_W-1:0]                   in_sb,
	output logic                              out_vld,
	output logic signed [tlik_pkg::ANG_W-1:0] angle [tlik_pkg::NUM_LANES],
	output logic [SB_W-1:0]                   out_sb
);
	import tlik_pkg::*;
	localparam int LAT = ITER + 5;
	localparam int FL  = ITER + 4;

	logic [LAT-1:0]          vld_s;
	logic [SB_W-1:0]         sb_s  [LAT];
	lane_flag_t              flg_s [FL][NUM_LANES];
	logic [MAG_W-1:0]        ax_c1 [NUM_LANES];
	logic [MAG_W-1:0]        ay_c1 [NUM_LANES];
	logic [MAG_W-1:0]        ax_c2 [NUM_LANES];
	logic [MAG_W-1:0]        ay_c2 [NUM_LANES];
	logic [MAG_W-1:0]        m_c2  [NUM_LANES];
	logic [MAG_W-1:0]        ax_c3 [NUM_LANES];
	logic [MAG_W-1:0]        ay_c3 [NUM_LANES];
	logic [POS_W-1:0]        pos_c3 [NUM_LANES];
	logic signed [CX_W-1:0]  cx_s  [ITER+1][NUM_LANES];
	logic signed [CX_W-1:0]  cy_s  [ITER+1][NUM_LANES];
	logic signed [Z_W-1:0]   z_s   [ITER+1][NUM_LANES];
	logic signed [ANG_W-1:0] ang_q [NUM_LANES];

	// position of the leading one
	function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (v[b]) p = POS_W'(b);
		end
		return p;
	endfunction

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= {vld_s[LAT-2:0], ctl.vld};
		end
	end

	// sideband and flag delay lines
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sb_s[0] <= in_sb;
			for (int k = 1; k < LAT; k++) sb_s[k] <= sb_s[k-1];
			for (int l = 0; l < NUM_LANES; l++) begin
				flg_s[0][l].xneg <= xv[l][SIG_W-1];
				flg_s[0][l].yneg <= yv[l][SIG_W-1];
				flg_s[0][l].zero <= (xv[l] == '0) && (yv[l] == '0);
			end
			for (int k = 1; k < FL; k++) flg_s[k] <= flg_s[k-1];
		end
	end

	// magnitudes, maximum, leading one, normalising shift
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				ax_c1[l] <= xv[l][SIG_W-1] ? MAG_W'(-xv[l]) : MAG_W'(xv[l]);
				ay_c1[l] <= yv[l][SIG_W-1] ? MAG_W'(-yv[l]) : MAG_W'(yv[l]);

				ax_c2[l] <= ax_c1[l];
				ay_c2[l] <= ay_c1[l];
				m_c2[l]  <= (ax_c1[l] > ay_c1[l]) ? ax_c1[l] : ay_c1[l];

				ax_c3[l]  <= ax_c2[l];
				ay_c3[l]  <= ay_c2[l];
				pos_c3[l] <= lead_pos(m_c2[l]);

				if (pos_c3[l] >= POS_W'(NORM_MSB)) begin
					cx_s[0][l] <= $signed(CX_W'((NORM_MSB+1)'(
						ax_c3[l] >> (pos_c3[l] - POS_W'(NORM_MSB)))));
					cy_s[0][l] <= $signed(CX_W'((NORM_MSB+1)'(
						ay_c3[l] >> (pos_c3[l] - POS_W'(NORM_MSB)))));
				end else begin
					cx_s[0][l] <= $signed(CX_W'((NORM_MSB+1)'(
						ax_c3[l] << (POS_W'(NORM_MSB) - pos_c3[l]))));
					cy_s[0][l] <= $signed(CX_W'((NORM_MSB+1)'(
						ay_c3[l] << (POS_W'(NORM_MSB) - pos_c3[l]))));
				end
				z_s[0][l] <= '0;
			end
		end
	end

	// rotation steps, one per stage
	for (genvar i = 0; i < ITER; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					if (!cy_s[i][l][CX_W-1]) begin
						cx_s[i+1][l] <= cx_s[i][l] + (cy_s[i][l] >>> i);
						cy_s[i+1][l] <= cy_s[i][l] - (cx_s[i][l] >>> i);
						z_s[i+1][l]  <= z_s[i][l] + $signed(Z_W'(ATAN_TAB[i]));
					end else begin
						cx_s[i+1][l] <= cx_s[i][l] - (cy_s[i][l] >>> i);
						cy_s[i+1][l] <= cy_s[i][l] + (cx_s[i][l] >>> i);
						z_s[i+1][l]  <= z_s[i][l] - $signed(Z_W'(ATAN_TAB[i]));
					end
				end
			end
		end
	end

	// clamp to the first quadrant and unfold by operand signs
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				logic signed [Z_W-1:0] zc;
				logic signed [Z_W-1:0] q;
				zc = z_s[ITER][l];
				if (zc < 0) zc = '0;
				if (zc > DEG_90) zc = DEG_90;
				q = flg_s[FL-1][l].xneg ? (DEG_180 - zc) : zc;
				q = flg_s[FL-1][l].yneg ? -q : q;
				ang_q[l] <= flg_s[FL-1][l].zero ? '0 : ANG_W'(q);
			end
		end
	end

	assign out_vld = vld_s[LAT-1];
	assign out_sb  = sb_s[LAT-1];
	assign angle   = ang_q;
endmodule
`default_nettype wire

/* src/two_link_planar_inverse_kinematics.sv */
// Two-link planar arm inverse kinematics, elbow-down. One target word (x, y in signed
// Q7.8) is taken every clock while the pipe advances, and one result word leaves per
// target, in order: five front stages form the cosine numerator and denominator and the
// radicand, a 31-stage square root gives one root bit a stage, a two-stage product/sum
// feeds three parallel cordic lanes (four normalising stages, one stage per iteration,
// one quadrant stage), and five stages round, clamp and turn the angles into servo
// counts. The whole pipe advances together whenever the output register is empty or
// being taken. Link lengths are written through the cfg port; the user must do so only
// while no target is in flight, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module two_link_planar_inverse_kinematics #(
	parameter int CORDIC_ITERATIONS = tlik_pkg::ITER_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write port
	input  logic                                  cfg_wr_en,
	input  logic [tlik_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tlik_pkg::LINK_W-1:0]           cfg_data,
	// target words
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [tlik_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // target_x, target_y
	// result words
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// reachable, shoulder_angle, elbow_angle, shoulder_servo_count,
	// elbow_servo_count, count_clipped
	output logic [tlik_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
	import tlik_pkg::*;

	logic                        en;
	logic [LINK_W-1:0]           upper_q, lower_q;
	logic signed [COORD_W-1:0]   x_in, y_in;
	logic signed [2*COORD_W-1:0] xx_d, yy_d;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11;

	logic signed [COORD_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic [LINK_W-1:0]         l1_s1, l2_s1, l1_s2, l2_s2, l1_s3, l2_s3;
	logic [LINK_W-1:0]         l1_s4, l2_s4, l1_s5, l2_s5;
	logic [SQ_W-1:0]           xx_s1, yy_s1;
	logic [LSQ_W-1:0]          l11_s1, l22_s1, l12_s1;
	logic signed [NUM_W-1:0]   num_s2, num_s3, num_s4, num_s5;
	logic [DEN_W-1:0]          den_s2, den_s3, den_s4, den_s5;
	logic [NUM_W-1:0]          anum_d;
	logic [DEN_W-1:0]          anum_s3;
	logic                      reach_s3, reach_s4, reach_s5;
	logic [RAD_W-1:0]          dd_s4, nn_s4, rad_s5;

	sq_sb_t                    sq_in, sq_out;
	pipe_ctl_t                 sq_ctl, cd_ctl;
	logic                      sq_vld;
	logic [ROOT_W-1:0]         sq_root;

	logic signed [COORD_W-1:0] x_s6, y_s6;
	logic signed [NUM_W-1:0]   num_s6;
	logic [ROOT_W-1:0]         root_s6;
	logic                      reach_s6;
	logic [MAG_W-1:0]          l2s_s6, l1d_s6;
	logic signed [SIG_W-1:0]   l2n_s6;
	logic signed [SIG_W-1:0]   lx_s7 [NUM_LANES];
	logic signed [SIG_W-1:0]   ly_s7 [NUM_LANES];
	logic                      reach_s7;

	logic                      cd_vld, cd_reach;
	logic signed [ANG_W-1:0]   cd_ang [NUM_LANES];
	logic signed [T_W-1:0]     r1_d, r2_d;

	logic                      reach_s8, reach_s9, reach_s10, reach_s11;
	logic signed [A1_W-1:0]    a1_s8;
	logic signed [A2_W-1:0]    a2_s8;
	logic signed [SH_ANG_W-1:0] a1_s9, a1_s10, a1_s11;
	logic [EL_ANG_W-1:0]       a2_s9, a2_s10, a2_s11;
	logic [N_W-1:0]            n1_s10, n2_s10;
	logic [PROD_W-1:0]         p1_s11, p2_s11;
	logic [CNT_W-1:0]          c1_d, c2_d;

	logic                      out_vld_s12;
	logic                      reach_s12, clip_s12;
	logic signed [SH_ANG_W-1:0] a1_s12;
	logic [EL_ANG_W-1:0]       a2_s12;
	logic [SERVO_W-1:0]        cnt1_s12, cnt2_s12;

	// whole pipe moves when the output register is free
	assign en            = !out_vld_s12 || m_axis_tready;
	assign s_axis_tready = en;

	// link length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_UPPER: upper_q <= cfg_data;
				REG_LOWER: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
			{vld_s8, vld_s9, vld_s10, vld_s11, out_vld_s12} <= '0;
		end else if (en) begin
			vld_s1      <= s_axis_tvalid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= sq_vld;
			vld_s7      <= vld_s6;
			vld_s8      <= cd_vld;
			vld_s9      <= vld_s8;
			vld_s10     <= vld_s9;
			vld_s11     <= vld_s10;
			out_vld_s12 <= vld_s11;
		end
	end

	assign x_in = $signed(s_axis_tdata[COORD_W-1:0]);
	assign y_in = $signed(s_axis_tdata[2*COORD_W-1:COORD_W]);
	assign xx_d = x_in * x_in;
	assign yy_d = y_in * y_in;
	assign anum_d = num_s2[NUM_W-1] ? NUM_W'(-num_s2) : NUM_W'(num_s2);

	// front: squares, cosine numerator and denominator, reach test, radicand
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			l1_s1  <= upper_q;
			l2_s1  <= lower_q;
			xx_s1  <= xx_d[SQ_W-1:0];
			yy_s1  <= yy_d[SQ_W-1:0];
			l11_s1 <= LSQ_W'(upper_q) * LSQ_W'(upper_q);
			l22_s1 <= LSQ_W'(lower_q) * LSQ_W'(lower_q);
			l12_s1 <= LSQ_W'(upper_q) * LSQ_W'(lower_q);

			{x_s2, y_s2, l1_s2, l2_s2} <= {x_s1, y_s1, l1_s1, l2_s1};
			num_s2 <= $signed(NUM_W'(xx_s1)) + $signed(NUM_W'(yy_s1))
				- $signed(NUM_W'(l11_s1)) - $signed(NUM_W'(l22_s1));
			den_s2 <= {l12_s1, 1'b0};

			{x_s3, y_s3, l1_s3, l2_s3} <= {x_s2, y_s2, l1_s2, l2_s2};
			num_s3   <= num_s2;
			den_s3   <= den_s2;
			anum_s3  <= anum_d[DEN_W-1:0];
			reach_s3 <= (den_s2 != '0) && (anum_d <= NUM_W'(den_s2));

			{x_s4, y_s4, l1_s4, l2_s4} <= {x_s3, y_s3, l1_s3, l2_s3};
			num_s4   <= num_s3;
			den_s4   <= den_s3;
			reach_s4 <= reach_s3;
			dd_s4    <= RAD_W'(den_s3) * RAD_W'(den_s3);
			nn_s4    <= RAD_W'(anum_s3) * RAD_W'(anum_s3);

			{x_s5, y_s5, l1_s5, l2_s5} <= {x_s4, y_s4, l1_s4, l2_s4};
			num_s5   <= num_s4;
			den_s5   <= den_s4;
			reach_s5 <= reach_s4;
			rad_s5   <= reach_s4 ? (dd_s4 - nn_s4) : '0;
		end
	end

	// sine numerator by square root
	assign sq_ctl = '{en: en, vld: vld_s5};
	assign sq_in  = '{x: x_s5, y: y_s5, l1: l1_s5, l2: l2_s5, num: num_s5, den: den_s5,
		reach: reach_s5};

	tlik_sqrt #(
		.SB_W ($bits(sq_sb_t))
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sq_ctl),
		.rad     (rad_s5),
		.in_sb   (sq_in),
		.out_vld (sq_vld),
		.root    (sq_root),
		.out_sb  (sq_out)
	);

	// offset arctangent operands and lane setup
	always_ff @(posedge clk) begin
		if (en) begin
			x_s6     <= sq_out.x;
			y_s6     <= sq_out.y;
			num_s6   <= sq_out.num;
			root_s6  <= sq_root;
			reach_s6 <= sq_out.reach;
			l2s_s6   <= MAG_W'(sq_out.l2) * MAG_W'(sq_root);
			l1d_s6   <= MAG_W'(sq_out.l1) * MAG_W'(sq_out.den);
			l2n_s6   <= SIG_W'($signed({1'b0, sq_out.l2})) * SIG_W'(sq_out.num);

			reach_s7 <= reach_s6;
			lx_s7[LANE_YX]  <= SIG_W'(x_s6);
			ly_s7[LANE_YX]  <= SIG_W'(y_s6);
			lx_s7[LANE_ELB] <= SIG_W'(num_s6);
			ly_s7[LANE_ELB] <= $signed(SIG_W'(root_s6));
			lx_s7[LANE_OFF] <= $signed(SIG_W'(l1d_s6)) + l2n_s6;
			ly_s7[LANE_OFF] <= $signed(SIG_W'(l2s_s6));
		end
	end

	assign cd_ctl = '{en: en, vld: vld_s7};

	tlik_cordic #(
		.ITER (CORDIC_ITERATIONS),
		.SB_W (1)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cd_ctl),
		.xv      (lx_s7),
		.yv      (ly_s7),
		.in_sb   (reach_s7),
		.out_vld (cd_vld),
		.angle   (cd_ang),
		.out_sb  (cd_reach)
	);

	// angle difference and rounding to 1/64 degree
	assign r1_d = T_W'(cd_ang[LANE_YX]) - T_W'(cd_ang[LANE_OFF]) + T_W'(512);
	assign r2_d = T_W'(cd_ang[LANE_ELB]) + T_W'(512);

	// servo count quotients, exact for numerators below 2^19
	assign c1_d = p1_s11[RECIP_SH +: CNT_W];
	assign c2_d = p2_s11[RECIP_SH +: CNT_W];

	// back end: clamp, servo numerator, reciprocal product, saturation
	always_ff @(posedge clk) begin
		if (en) begin
			reach_s8 <= cd_reach;
			a1_s8    <= r1_d[RND_SH +: A1_W];
			a2_s8    <= r2_d[RND_SH +: A2_W];

			reach_s9 <= reach_s8;
			if (a1_s8 < SHOULDER_MIN)      a1_s9 <= SH_ANG_W'(SHOULDER_MIN);
			else if (a1_s8 > SHOULDER_MAX) a1_s9 <= SH_ANG_W'(SHOULDER_MAX);
			else                           a1_s9 <= SH_ANG_W'(a1_s8);
			if (a2_s8 < 0)                 a2_s9 <= '0;
			else if (a2_s8 > ELBOW_MAX)    a2_s9 <= EL_ANG_W'(ELBOW_MAX);
			else                           a2_s9 <= EL_ANG_W'(a2_s8);

			reach_s10 <= reach_s9;
			a1_s10    <= a1_s9;
			a2_s10    <= a2_s9;
			n1_s10    <= N_W'(SERVO_MID_X8 - $signed({a1_s9[SH_ANG_W-1], a1_s9, 3'b000}));
			n2_s10    <= N_W'(SERVO_MID_X8 - $signed({3'b000, a2_s9, 3'b000}));

			reach_s11 <= reach_s10;
			a1_s11    <= a1_s10;
			a2_s11    <= a2_s10;
			p1_s11    <= PROD_W'(n1_s10) * PROD_W'(RECIP_45);
			p2_s11    <= PROD_W'(n2_s10) * PROD_W'(RECIP_45);

			reach_s12 <= reach_s11;
			if (reach_s11) begin
				a1_s12   <= a1_s11;
				a2_s12   <= a2_s11;
				cnt1_s12 <= (c1_d > SERVO_MAX) ? SERVO_W'(SERVO_MAX) : SERVO_W'(c1_d);
				cnt2_s12 <= (c2_d > SERVO_MAX) ? SERVO_W'(SERVO_MAX) : SERVO_W'(c2_d);
				clip_s12 <= (c1_d > SERVO_MAX) || (c2_d > SERVO_MAX);
			end else begin
				a1_s12   <= '0;
				a2_s12   <= '0;
				cnt1_s12 <= '0;
				cnt2_s12 <= '0;
				clip_s12 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_s12;
	assign m_axis_tdata  = {clip_s12, cnt2_s12, cnt1_s12, a2_s12, a1_s12, reach_s12};
endmodule
`default_nettype wire

/* src/tlik_checker.sv */
// port-level checks of the two-link arm solver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tlik_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
`include "two_link_planar_inverse_kinematics_assert.svh"

	// an unreachable target carries nothing but the flag
	`TLIK_ASSERT_IMP(a_unreach_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[55:1] == '0, "unreachable word has nonzero fields")

	// elbow stays within half a turn
	`TLIK_ASSERT_IMP(a_elbow_range, m_axis_tvalid, m_axis_tdata[30:17] <= 14'd11520, "elbow angle above 180 degrees")

	// only the shoulder can clip, and only at the top rail
	`TLIK_ASSERT_IMP(a_clip_rail, m_axis_tvalid && m_axis_tdata[55], m_axis_tdata[42:31] == 12'd4095, "clip flag without shoulder count at full scale")

	// a stalled result word is held
	`TLIK_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

	// input side opens whenever the output is being drained
	`TLIK_ASSERT_IMP(a_ready_drain, m_axis_tready, s_axis_tready, "input stalled while output drains")
endmodule

bind two_link_planar_inverse_kinematics tlik_checker u_tlik_checker (.*);
`default_nettype wire
